// File: src/iws_pkg.sv
// Shared constants, types and codes for the interval window splitter.
`timescale 1ns / 1ps
`default_nettype none

package iws_pkg;

	// Field widths and limits.
	localparam int unsigned COORD_W     = 31;
	localparam int unsigned ROW_W       = 32;
	localparam int unsigned MAX_WINDOWS = 64;
	localparam int unsigned CNT_W       = $clog2(MAX_WINDOWS + 1);

	// Divider operands hold twice a length plus a count, or a length plus two sizes.
	localparam int unsigned DIV_W     = COORD_W + 2;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

	// Register port geometry.
	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	// Register indexes, taken from paddr[3:2].
	typedef enum logic [1:0] {
		REG_WINDOW_SIZE  = 2'd0,
		REG_WINDOW_COUNT = 2'd1,
		REG_STEP         = 2'd2,
		REG_REVERSE_IDS  = 2'd3
	} reg_idx_t;

	// Configuration register contents.
	typedef struct packed {
		logic [COORD_W-1:0] window_size;
		logic [COORD_W-1:0] window_count;
		logic [COORD_W-1:0] step;
		logic               reverse_ids;
	} cfg_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV1,
		ST_MID,
		ST_DIV2,
		ST_SETUP,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic prep;
		logic div_start1;
		logic take_q1;
		logic div_start2;
		logic take_q2;
		logic setup;
		logic advance;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic skip;
		logic div_done;
		logic out_free;
		logic last_win;
	} status_t;

endpackage

`default_nettype wire

// File: src/interval_window_splitter_unit.sv
// Top level of the interval window splitter: registers, controller and datapath.
// From an accepted interval to its first window: prep, a serial division (33 quotient bits
// and a hand-over), the middle step, a second division, setup and the first emit.
// Throughput: one window per cycle unless win_stall holds; no windows means idle after prep.
// A new interval is accepted once the last window of the previous one is in the output register.
// Reset (arst_n low, asynchronous) clears the registers, the row counter and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module interval_window_splitter_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [iws_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [iws_pkg::DATA_W-1:0]  pwdata,
	output logic      [iws_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,
	input  wire logic                        ivl_valid,
	output logic                             ivl_stall,
	input  wire logic [iws_pkg::COORD_W-1:0] ivl_start,
	input  wire logic [iws_pkg::COORD_W-1:0] ivl_end,
	output logic                             win_valid,
	input  wire logic                        win_stall,
	output logic      [iws_pkg::COORD_W-1:0] win_start,
	output logic      [iws_pkg::COORD_W-1:0] win_end,
	output logic      [iws_pkg::COORD_W-1:0] win_number,
	output logic      [iws_pkg::ROW_W-1:0]   row_index,
	output logic                             last,
	output logic                             truncated
);
	import iws_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	// Configuration registers.
	iws_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer.
	iws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.ivl_valid (ivl_valid),
		.ivl_stall (ivl_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Arithmetic and output register.
	iws_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg        (cfg),
		.ivl_start  (ivl_start),
		.ivl_end    (ivl_end),
		.win_valid  (win_valid),
		.win_stall  (win_stall),
		.win_start  (win_start),
		.win_end    (win_end),
		.win_number (win_number),
		.row_index  (row_index),
		.last       (last),
		.truncated  (truncated)
	);

endmodule

`default_nettype wire

// File: src/iws_regs.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module iws_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [iws_pkg::ADDR_W-1:0] paddr,
	input  wire logic [iws_pkg::DATA_W-1:0] pwdata,
	output logic      [iws_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	output iws_pkg::cfg_t                   cfg
);
	import iws_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes complete in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_WINDOW_SIZE:  cfg_q.window_size  <= pwdata[COORD_W-1:0];
				REG_WINDOW_COUNT: cfg_q.window_count <= pwdata[COORD_W-1:0];
				REG_STEP:         cfg_q.step         <= pwdata[COORD_W-1:0];
				REG_REVERSE_IDS:  cfg_q.reverse_ids  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read-back of the selected register.
	always_comb begin
		case (idx)
			REG_WINDOW_SIZE:  prdata = DATA_W'(cfg_q.window_size);
			REG_WINDOW_COUNT: prdata = DATA_W'(cfg_q.window_count);
			REG_STEP:         prdata = DATA_W'(cfg_q.step);
			REG_REVERSE_IDS:  prdata = DATA_W'(cfg_q.reverse_ids);
			default:          prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: src/iws_div.sv
// Restoring divider producing one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module iws_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [iws_pkg::DIV_W-1:0] dividend,
	input  wire logic [iws_pkg::DIV_W-1:0] divisor,
	output logic      [iws_pkg::DIV_W-1:0] quotient,
	output logic                           done
);
	import iws_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     dvs_q;
	logic [DIV_W:0]       shifted;
	logic [DIV_W:0]       diff;
	logic                 ge;

	// One trial subtraction of the divisor from the partial remainder.
	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign ge      = !diff[DIV_W];

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

`default_nettype wire

// File: src/iws_ctrl.sv
// Sequencing state machine for the interval window splitter.
`timescale 1ns / 1ps
`default_nettype none

module iws_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             ivl_valid,
	output logic                  ivl_stall,
	input  wire iws_pkg::status_t status,
	output iws_pkg::cmd_t         cmd
);
	import iws_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (ivl_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				if (status.skip) begin
					state_d = ST_IDLE;
				end else begin
					cmd.div_start1 = 1'b1;
					state_d        = ST_DIV1;
				end
			end
			ST_DIV1: begin
				if (status.div_done) begin
					cmd.take_q1 = 1'b1;
					state_d     = ST_MID;
				end
			end
			ST_MID: begin
				cmd.div_start2 = 1'b1;
				state_d        = ST_DIV2;
			end
			ST_DIV2: begin
				if (status.div_done) begin
					cmd.take_q2 = 1'b1;
					state_d     = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.advance = 1'b1;
					if (status.last_win) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign ivl_stall = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// File: src/iws_datapath.sv
// Interval registers, two divisions (window size and count, or two count bounds), window walk and output register.
`timescale 1ns / 1ps
`default_nettype none

module iws_datapath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire iws_pkg::cmd_t               cmd,
	output iws_pkg::status_t                 status,
	input  wire iws_pkg::cfg_t               cfg,
	input  wire logic [iws_pkg::COORD_W-1:0] ivl_start,
	input  wire logic [iws_pkg::COORD_W-1:0] ivl_end,
	output logic                             win_valid,
	input  wire logic                        win_stall,
	output logic      [iws_pkg::COORD_W-1:0] win_start,
	output logic      [iws_pkg::COORD_W-1:0] win_end,
	output logic      [iws_pkg::COORD_W-1:0] win_number,
	output logic      [iws_pkg::ROW_W-1:0]   row_index,
	output logic                             last,
	output logic                             truncated
);
	import iws_pkg::*;

	// Interval and per-item registers.
	logic [COORD_W-1:0] s_q;
	logic [COORD_W-1:0] e_q;
	logic [COORD_W:0]   len_q;
	logic [ROW_W-1:0]   row_q;
	logic [ROW_W-1:0]   row_cnt_q;
	logic [COORD_W-1:0] size_q;
	logic [COORD_W-1:0] by_q;
	logic [DIV_W-1:0]   lim_q;
	logic [DIV_W-1:0]   c1_q;
	logic [COORD_W-1:0] total_q;
	logic [CNT_W-1:0]   emit_q;
	logic               trunc_q;
	logic [COORD_W-1:0] ws_q;
	logic [COORD_W-1:0] left_q;
	logic [CNT_W-1:0]   fwd_q;

	// Output register.
	logic               out_valid_q;
	logic [COORD_W-1:0] out_start_q;
	logic [COORD_W-1:0] out_end_q;
	logic [COORD_W-1:0] out_number_q;
	logic [ROW_W-1:0]   out_row_q;
	logic               out_last_q;
	logic               out_trunc_q;

	// Combinational terms.
	logic [COORD_W:0]   len_c;
	logic               count_mode;
	logic               len_pos;
	logic               short_ivl;
	logic [COORD_W-1:0] by_c;
	logic [COORD_W+2:0] lim_c;
	logic [DIV_W-1:0]   dvd;
	logic [DIV_W-1:0]   dvs;
	logic [DIV_W-1:0]   quo;
	logic               div_done;
	logic [DIV_W-1:0]   q2p;
	logic [COORD_W:0]   sum_c;
	logic               clip;

	assign len_c      = {1'b0, ivl_end} - {1'b0, ivl_start};
	assign count_mode = (cfg.window_count != '0);
	assign len_pos    = !len_q[COORD_W] && (len_q != '0);
	assign short_ivl  = (len_q[COORD_W-1:0] < cfg.window_count);
	assign by_c       = (cfg.step != '0) ? cfg.step : cfg.window_size;
	assign lim_c      = {3'b000, len_q[COORD_W-1:0]} - {3'b000, cfg.window_size}
		+ {3'b000, by_c};

	// An interval yields nothing when empty or reversed, too short, or with a zero sliding step.
	assign status.skip = !len_pos
		|| (count_mode ? short_ivl : ((by_c == '0) || lim_c[COORD_W+2]));

	// Divider operands: window size then count in count mode, both quotients in sliding mode.
	always_comb begin
		if (cmd.div_start1) begin
			if (count_mode) begin
				dvd = {1'b0, len_q[COORD_W-1:0], 1'b0} + {2'b00, cfg.window_count};
				dvs = {1'b0, cfg.window_count, 1'b0};
			end else begin
				dvd = {2'b00, len_q[COORD_W-1:0] - 1'b1};
				dvs = {2'b00, by_c};
			end
		end else begin
			if (count_mode) begin
				dvd = {2'b00, len_q[COORD_W-1:0]} + {2'b00, size_q} - DIV_W'(1);
				dvs = {2'b00, size_q};
			end else begin
				dvd = lim_q;
				dvs = {2'b00, by_q};
			end
		end
	end

	iws_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start1 || cmd.div_start2),
		.dividend (dvd),
		.divisor  (dvs),
		.quotient (quo),
		.done     (div_done)
	);

	assign status.div_done = div_done;
	assign q2p             = quo + DIV_W'(1);

	// Window end: start plus size, unless that overruns the interval or this is the final window.
	assign sum_c = {1'b0, ws_q} + {1'b0, size_q};
	assign clip  = !(sum_c < {1'b0, e_q}) || (left_q == COORD_W'(1));

	assign status.last_win = (fwd_q == emit_q);
	assign status.out_free = !out_valid_q || !win_stall;

	// Row counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				row_cnt_q <= row_cnt_q + 1'b1;
			end
			if (cmd.advance) begin
				out_valid_q <= 1'b1;
			end else if (!win_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Per-item working registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			s_q   <= ivl_start;
			e_q   <= ivl_end;
			len_q <= len_c;
			row_q <= row_cnt_q;
		end
		if (cmd.prep) begin
			by_q   <= by_c;
			size_q <= cfg.window_size;
			lim_q  <= lim_c[DIV_W-1:0];
		end
		if (cmd.take_q1) begin
			if (count_mode) begin
				size_q <= quo[COORD_W-1:0];
				by_q   <= quo[COORD_W-1:0];
			end else begin
				c1_q <= q2p;
			end
		end
		if (cmd.take_q2) begin
			if (count_mode) begin
				total_q <= (quo < {2'b00, cfg.window_count}) ? quo[COORD_W-1:0]
					: cfg.window_count;
			end else begin
				total_q <= (c1_q < q2p) ? c1_q[COORD_W-1:0] : q2p[COORD_W-1:0];
			end
		end
		if (cmd.setup) begin
			trunc_q <= (total_q > COORD_W'(MAX_WINDOWS));
			emit_q  <= (total_q > COORD_W'(MAX_WINDOWS)) ? CNT_W'(MAX_WINDOWS)
				: total_q[CNT_W-1:0];
			ws_q    <= s_q;
			left_q  <= total_q;
			fwd_q   <= CNT_W'(1);
		end
		if (cmd.advance) begin
			ws_q   <= ws_q + by_q;
			left_q <= left_q - 1'b1;
			fwd_q  <= fwd_q + 1'b1;
		end
	end

	// Output payload register, loaded with each window.
	always_ff @(posedge clk) begin
		if (cmd.advance) begin
			out_start_q  <= ws_q;
			out_end_q    <= clip ? e_q : sum_c[COORD_W-1:0];
			out_number_q <= cfg.reverse_ids ? left_q : COORD_W'(fwd_q);
			out_row_q    <= row_q;
			out_last_q   <= status.last_win;
			out_trunc_q  <= trunc_q;
		end
	end

	assign win_valid  = out_valid_q;
	assign win_start  = out_start_q;
	assign win_end    = out_end_q;
	assign win_number = out_number_q;
	assign row_index  = out_row_q;
	assign last       = out_last_q;
	assign truncated  = out_trunc_q;

endmodule

`default_nettype wire

// File: src/iws_checker.sv
// Port-level assertions for the interval window splitter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module iws_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        ivl_valid,
	input wire logic                        ivl_stall,
	input wire logic                        win_valid,
	input wire logic                        win_stall,
	input wire logic [iws_pkg::COORD_W-1:0] win_start,
	input wire logic [iws_pkg::COORD_W-1:0] win_end,
	input wire logic [iws_pkg::COORD_W-1:0] win_number,
	input wire logic                        last
);
	import iws_pkg::*;

	// A stalled window transaction keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(win_valid && win_stall) |=> (win_valid && $stable(win_start)
			&& $stable(win_end) && $stable(win_number) && $stable(last)))
		else $error("window payload changed while stalled");

	// Only one interval is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(ivl_valid && !ivl_stall) |=> ivl_stall)
		else $error("second interval accepted straight after the first");

	// A fresh window only appears while an interval is being split.
	a_win_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(win_valid) |-> $past(ivl_stall))
		else $error("window appeared while the splitter was idle");

	// Before the final window of an interval, no new interval is taken.
	a_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(win_valid && !last) |-> ivl_stall)
		else $error("interval accepted before its predecessor's final window");

	// Window ids are one-based.
	a_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		win_valid |-> (win_number != '0))
		else $error("window id of zero");

endmodule

bind interval_window_splitter_unit iws_checker u_iws_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.ivl_valid  (ivl_valid),
	.ivl_stall  (ivl_stall),
	.win_valid  (win_valid),
	.win_stall  (win_stall),
	.win_start  (win_start),
	.win_end    (win_end),
	.win_number (win_number),
	.last       (last)
);

`default_nettype wire
